// ===== sv/les_pkg.sv =====
package les_pkg;

  localparam int LED_COUNT = 6;
  localparam int LED_W = $clog2(LED_COUNT + 1);
  localparam int K_W = $clog2(LED_COUNT);
  localparam int CD_W = 8;
  localparam int LVL_W = 6;
  localparam int COLOR_W = 8;
  localparam int PROD_W = COLOR_W + LVL_W;
  localparam int MUL_W = 16;
  localparam int RECIP_SH = 20;
  localparam int ADDR_W = 5;

  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_SPEED = 3'd1;
  localparam logic [2:0] REG_RED   = 3'd2;
  localparam logic [2:0] REG_GREEN = 3'd3;
  localparam logic [2:0] REG_BLUE  = 3'd4;
  localparam logic [2:0] REG_BLED  = 3'd5;

  localparam logic [1:0] MODE_METEOR = 2'd1;
  localparam logic [1:0] MODE_BREATH = 2'd2;

  localparam logic [1:0] SPEED_SLOW = 2'd0;
  localparam logic [1:0] SPEED_MED  = 2'd1;
  localparam logic [1:0] SPEED_FAST = 2'd2;

  function automatic logic [1:0] sat_speed(input logic [1:0] s);
    sat_speed = (s > SPEED_FAST) ? SPEED_FAST : s;
  endfunction

  function automatic logic [CD_W-1:0] meteor_period(input logic [1:0] s);
    unique case (s)
      SPEED_SLOW: meteor_period = CD_W'(200);
      SPEED_MED:  meteor_period = CD_W'(140);
      default:    meteor_period = CD_W'(80);
    endcase
  endfunction

  function automatic logic [LVL_W-1:0] breath_span(input logic [1:0] s);
    unique case (s)
      SPEED_SLOW: breath_span = LVL_W'(50);
      SPEED_MED:  breath_span = LVL_W'(35);
      default:    breath_span = LVL_W'(25);
    endcase
  endfunction

endpackage

// ===== sv/les_div_unit.sv =====
module les_div_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [les_pkg::COLOR_W-1:0] color,
  input  logic [les_pkg::LVL_W-1:0]   level,
  input  logic [les_pkg::LVL_W-1:0]   span,
  output logic                        done,
  output logic [les_pkg::COLOR_W-1:0] quot
);
  import les_pkg::*;

  logic [MUL_W-1:0]   op_a;
  logic [MUL_W-1:0]   op_b;
  logic [2*MUL_W-1:0] prod;
  logic [MUL_W-1:0]   recip;
  logic [PROD_W-1:0]  x;
  logic               busy;

  // floor(x/span) as (x*recip) >> RECIP_SH, exact for x up to 255*span
  always_comb begin
    unique case (span)
      LVL_W'(50): recip = MUL_W'(20972);
      LVL_W'(35): recip = MUL_W'(29960);
      default:    recip = MUL_W'(41944);
    endcase
  end

  // one multiplier: color*level on start, then product*recip
  assign op_a = busy ? MUL_W'(x) : MUL_W'(color);
  assign op_b = busy ? recip : MUL_W'(level);
  assign prod = {{MUL_W{1'b0}}, op_a} * {{MUL_W{1'b0}}, op_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= prod[PROD_W-1:0];
    end else if (busy) begin
      quot <= prod[RECIP_SH+COLOR_W-1:RECIP_SH];
    end
  end

endmodule

// ===== sv/led_effect_sequencer_top.sv =====
// LED effect sequencer for a ring of six RGB LEDs. Each tick transfer is one
// millisecond (tick=1) or no time (tick=0); a due step produces its LED writes
// on the out channel, with last marking the write that latches the frame. A
// tick that causes no step leaves the sequencer idle, as does a breathing step
// on a LED past the ring. A meteor step issues one write per cycle while the
// output register is free. A breathing step sends its three color channels one
// after another through a single multiplier that forms color*level and then
// scales it by a reciprocal of the span. New ticks are refused until the
// current step has handed all its writes to the output register. A write to
// any of the six configuration registers over the APB port restarts
// the effect.
module led_effect_sequencer_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          tick,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    led,
  output logic [les_pkg::COLOR_W-1:0]   red_out,
  output logic [les_pkg::COLOR_W-1:0]   green_out,
  output logic [les_pkg::COLOR_W-1:0]   blue_out,
  output logic                          last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [les_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import les_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MET  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [1:0]         effect_mode;
  logic [1:0]         speed;
  logic [COLOR_W-1:0] red, green, blue;
  logic [2:0]         breath_led;

  logic [2:0]         st;
  logic [CD_W-1:0]    countdown;
  logic [LED_W-1:0]   meteor_position;
  logic [LVL_W-1:0]   breath_level;
  logic               breath_falling;
  logic [LED_W-1:0]   led_cur;
  logic [K_W-1:0]     k;
  logic [LVL_W-1:0]   lv;
  logic [LVL_W-1:0]   span;
  logic [1:0]         ch;
  logic [COLOR_W-1:0] q_red, q_green, q_blue;

  logic               cfg_wr;
  logic [2:0]         cfg_idx;
  logic               in_xfer;
  logic               out_free;
  logic [1:0]         s;
  logic [CD_W-1:0]    cd_dec;
  logic [LVL_W-1:0]   lv_clip;
  logic [LVL_W-1:0]   lv_next;
  logic               falling_next;
  logic [LVL_W-1:0]   span_now;
  logic [2:0]         sh1, sh2;
  logic               k_last;
  logic               div_start;
  logic               div_done;
  logic [COLOR_W-1:0] div_color;
  logic [COLOR_W-1:0] div_quot;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign cfg_idx  = paddr[4:2];
  assign in_ready = (st == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign s        = sat_speed(speed);
  assign span_now = breath_span(s);
  assign cd_dec   = (tick && countdown != '0) ? countdown - 1'b1 : countdown;
  assign lv_clip  = (breath_level > span_now) ? span_now : breath_level;
  assign sh1      = 3'd3 + {1'b0, s};
  assign sh2      = 3'd4 + {1'b0, s};
  assign k_last   = (k == K_W'(LED_COUNT - 1));

  always_comb begin
    lv_next      = lv_clip;
    falling_next = breath_falling;
    if (breath_falling) begin
      lv_next = (lv_clip > '0) ? lv_clip - 1'b1 : '0;
      if (lv_next <= LVL_W'(1)) begin
        lv_next      = LVL_W'(1);
        falling_next = 1'b0;
      end
    end else begin
      lv_next = lv_clip + 1'b1;
      if (lv_next >= span_now) begin
        lv_next      = span_now;
        falling_next = 1'b1;
      end
    end
  end

  always_comb begin
    unique case (ch)
      2'd0:    div_color = red;
      2'd1:    div_color = green;
      default: div_color = blue;
    endcase
  end

  assign div_start = (st == ST_MUL);

  les_div_unit u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .color (div_color),
    .level (lv),
    .span  (span),
    .done  (div_done),
    .quot  (div_quot)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      effect_mode <= '0;
      speed       <= '0;
      red         <= '0;
      green       <= '0;
      blue        <= '0;
      breath_led  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MODE:  effect_mode <= pwdata[1:0];
        REG_SPEED: speed       <= pwdata[1:0];
        REG_RED:   red         <= pwdata[COLOR_W-1:0];
        REG_GREEN: green       <= pwdata[COLOR_W-1:0];
        REG_BLUE:  blue        <= pwdata[COLOR_W-1:0];
        REG_BLED:  breath_led  <= pwdata[2:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MODE:  prdata = {30'd0, effect_mode};
      REG_SPEED: prdata = {30'd0, speed};
      REG_RED:   prdata = {24'd0, red};
      REG_GREEN: prdata = {24'd0, green};
      REG_BLUE:  prdata = {24'd0, blue};
      REG_BLED:  prdata = {29'd0, breath_led};
      default:   prdata = '0;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st              <= ST_IDLE;
      countdown       <= '0;
      meteor_position <= LED_W'(LED_COUNT);
      breath_level    <= '0;
      breath_falling  <= 1'b0;
      out_valid       <= 1'b0;
      k               <= '0;
      ch              <= '0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr && cfg_idx <= REG_BLED) begin
        countdown       <= '0;
        meteor_position <= LED_W'(LED_COUNT);
        breath_level    <= '0;
        breath_falling  <= 1'b0;
      end else begin
        unique case (st)
          ST_IDLE: begin
            if (in_xfer) begin
              countdown <= cd_dec;
              if (cd_dec == '0) begin
                if (effect_mode == MODE_METEOR) begin
                  countdown       <= meteor_period(s);
                  meteor_position <= (meteor_position >= LED_W'(LED_COUNT)) ?
                                     LED_W'(1) : meteor_position + 1'b1;
                  k               <= '0;
                  st              <= ST_MET;
                end else if (effect_mode == MODE_BREATH) begin
                  countdown      <= CD_W'(span_now);
                  breath_level   <= lv_next;
                  breath_falling <= falling_next;
                  ch             <= '0;
                  if (int'(breath_led) <= LED_COUNT) begin
                    st <= ST_MUL;
                  end
                end
              end
            end
          end
          ST_MET: begin
            if (out_free) begin
              out_valid <= 1'b1;
              k         <= k + 1'b1;
              if (k_last) begin
                st <= ST_IDLE;
              end
            end
          end
          ST_MUL: begin
            st <= ST_DIV;
          end
          ST_DIV: begin
            if (div_done) begin
              if (ch == 2'd2) begin
                st <= ST_EMIT;
              end else begin
                ch <= ch + 1'b1;
                st <= ST_MUL;
              end
            end
          end
          ST_EMIT: begin
            if (out_free) begin
              out_valid <= 1'b1;
              st        <= ST_IDLE;
            end
          end
          default: st <= ST_IDLE;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (st == ST_IDLE && in_xfer) begin
      led_cur <= meteor_position;
      lv      <= lv_clip;
      span    <= span_now;
    end
    if (st == ST_MET && out_free) begin
      led     <= led_cur[2:0];
      last    <= k_last;
      led_cur <= (led_cur == LED_W'(1)) ? LED_W'(LED_COUNT) : led_cur - 1'b1;
      if (k == '0) begin
        red_out   <= red;
        green_out <= green;
        blue_out  <= blue;
      end else if (k == K_W'(1)) begin
        red_out   <= red >> sh1;
        green_out <= green >> sh1;
        blue_out  <= blue >> sh1;
      end else if (k == K_W'(2)) begin
        red_out   <= red >> sh2;
        green_out <= green >> sh2;
        blue_out  <= blue >> sh2;
      end else begin
        red_out   <= '0;
        green_out <= '0;
        blue_out  <= '0;
      end
    end
    if (st == ST_DIV && div_done) begin
      if (ch == 2'd0) begin
        q_red <= div_quot;
      end
      if (ch == 2'd1) begin
        q_green <= div_quot;
      end
      if (ch == 2'd2) begin
        q_blue <= div_quot;
      end
    end
    if (st == ST_EMIT && out_free) begin
      led       <= breath_led;
      red_out   <= q_red;
      green_out <= q_green;
      blue_out  <= q_blue;
      last      <= 1'b1;
    end
  end

endmodule

// ===== sv/les_checker.sv =====
module les_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [2:0]                  led,
  input logic [les_pkg::COLOR_W-1:0] red_out,
  input logic [les_pkg::COLOR_W-1:0] green_out,
  input logic [les_pkg::COLOR_W-1:0] blue_out,
  input logic                        last
);
  import les_pkg::*;

  // stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(led) && $stable(red_out)
      && $stable(green_out) && $stable(blue_out) && $stable(last))
    else $error("out payload changed while stalled");

  // led numbers stay within 0 to LED_COUNT
  a_led_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (LED_COUNT > 7) || (int'(led) <= LED_COUNT))
    else $error("led out of range");

  // a frame in progress keeps the input closed
  a_frame_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("input open mid frame");

  // non-final writes are meteor writes, never all-LED writes
  a_mid_led: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> led != 3'd0 || LED_COUNT > 7)
    else $error("mid frame write to all LEDs");

endmodule

bind led_effect_sequencer_top les_checker u_les_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .led       (led),
  .red_out   (red_out),
  .green_out (green_out),
  .blue_out  (blue_out),
  .last      (last)
);

// ===== tb/led_effect_sequencer_top_test.sv =====
module led_effect_sequencer_top_test;
  import les_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam logic [2:0] REG_NONE = REG_BLED + 3'd1;

  typedef struct {
    logic [2:0]         led;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               last;
  } led_write_t;

  class led_write_board;
    logic [1:0]         mode;
    logic [1:0]         speed;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [2:0]         bled;
    int                 countdown;
    int                 head;
    int                 level;
    bit                 falling;
    led_write_t         due_writes[$];
    int                 predicted;
    int                 checked;
    int                 mismatches;

    function new();
      mode = '0;
      speed = '0;
      red = '0;
      green = '0;
      blue = '0;
      bled = '0;
      predicted = 0;
      checked = 0;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      countdown = 0;
      head = LED_COUNT;
      level = 0;
      falling = 0;
    endfunction

    function void note_config(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_MODE:  mode = value[1:0];
        REG_SPEED: speed = value[1:0];
        REG_RED:   red = value[7:0];
        REG_GREEN: green = value[7:0];
        REG_BLUE:  blue = value[7:0];
        REG_BLED:  bled = value[2:0];
        default:   return;
      endcase
      restart();
    endfunction

    // one tick transfer: run the countdown, then the step if one is due
    function void note_tick(bit t);
      int s;
      int sh;
      int span;
      int lv;
      s = int'((speed > SPEED_FAST) ? SPEED_FAST : speed);
      if (t && countdown > 0) countdown--;
      if (countdown != 0) return;
      if (mode == MODE_METEOR) begin
        if (head < 1 || head > LED_COUNT) head = LED_COUNT;
        case (s)
          SPEED_SLOW: countdown = 200;
          SPEED_MED:  countdown = 140;
          default:    countdown = 80;
        endcase
        // head, two dimmed trailing LEDs, then the rest off
        for (int k = 0; k < LED_COUNT; k++) begin
          sh = (k == 0) ? 0 : (k < 3) ? 2 + k + s : COLOR_W;
          due_writes.push_back('{3'((head - 1 + LED_COUNT - k) % LED_COUNT + 1),
                                 red >> sh, green >> sh, blue >> sh,
                                 k == LED_COUNT - 1});
          predicted++;
        end
        head = (head >= LED_COUNT) ? 1 : head + 1;
      end else if (mode == MODE_BREATH) begin
        case (s)
          SPEED_SLOW: span = 50;
          SPEED_MED:  span = 35;
          default:    span = 25;
        endcase
        lv = (level > span) ? span : level;
        countdown = span;
        if (bled <= LED_COUNT) begin
          due_writes.push_back('{bled, COLOR_W'(red * lv / span),
                                 COLOR_W'(green * lv / span),
                                 COLOR_W'(blue * lv / span), 1'b1});
          predicted++;
        end
        if (falling) begin
          lv = (lv > 0) ? lv - 1 : 0;
          if (lv <= 1) begin
            lv = 1;
            falling = 0;
          end
        end else begin
          lv++;
          if (lv >= span) begin
            lv = span;
            falling = 1;
          end
        end
        level = lv & 63;
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_write(led_write_t got);
      led_write_t want;
      if (due_writes.size() == 0) begin
        $error("LED write with none expected: led %0d rgb %0d %0d %0d last %0d",
               got.led, got.red, got.green, got.blue, got.last);
        mismatches++;
        return;
      end
      want = due_writes.pop_front();
      checked++;
      compare_field("led", 8'(want.led), 8'(got.led));
      compare_field("red_out", want.red, got.red);
      compare_field("green_out", want.green, got.green);
      compare_field("blue_out", want.blue, got.blue);
      compare_field("last", 8'(want.last), 8'(got.last));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               tick = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         led;
  logic [COLOR_W-1:0] red_out;
  logic [COLOR_W-1:0] green_out;
  logic [COLOR_W-1:0] blue_out;
  logic               last;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  led_write_board board = new();
  led_write_t     seen;
  int             send_idle = 25;
  int             recv_idle = 79;
  int             quiet_cycles = 0;
  int             ticks_sent = 0;
  int             settings = 0;

  led_effect_sequencer_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .tick      (tick),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .led       (led),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .last      (last),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #6 clk = ~clk;

  // output side: check each write transfer, random backpressure, watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        seen = '{led, red_out, green_out, blue_out, last};
        board.check_write(seen);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("led_effect_sequencer_top_test NOT OK");
        $finish;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  function automatic logic [31:0] noisy(logic [31:0] v, int w);
    return $urandom_range(1) ? (($urandom() << w) | v) : v;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.note_config(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_tick(input bit t);
    int gap;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    tick <= t;
    do @(posedge clk); while (!in_ready);
    board.note_tick(t);
    ticks_sent++;
  endtask

  // drain all writes, then allow for a breathing step that writes nothing
  task automatic settle();
    in_valid <= 1'b0;
    while (board.due_writes.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    settings++;
  endtask

  initial begin
    logic [1:0]         m;
    logic [2:0]         b;
    logic [COLOR_W-1:0] cr;
    logic [COLOR_W-1:0] cg;
    logic [COLOR_W-1:0] cb;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // off after reset: nothing written
    send_tick(1);
    send_tick(0);

    settle();
    write_reg(REG_MODE, 32'(MODE_METEOR));
    write_reg(REG_RED, 32'd255);
    write_reg(REG_GREEN, 32'd255);
    write_reg(REG_BLUE, 32'd255);
    send_tick(0);
    send_tick(1);

    settle();
    write_reg(REG_SPEED, 32'(SPEED_FAST));
    send_tick(1);

    settle();
    write_reg(REG_SPEED, 32'hFFFF_FFFF);
    send_tick(1);

    settle();
    write_reg(REG_SPEED, 32'(SPEED_MED));
    write_reg(REG_RED, 32'h81);
    write_reg(REG_GREEN, 32'h7F);
    write_reg(REG_BLUE, 32'h80);
    send_tick(0);
    send_tick(1);

    settle();
    write_reg(REG_RED, 32'd0);
    write_reg(REG_GREEN, 32'd0);
    write_reg(REG_BLUE, 32'd0);
    send_tick(1);

    settle();
    write_reg(REG_RED, 32'd255);
    write_reg(REG_MODE, 32'(MODE_BREATH));
    write_reg(REG_BLED, 32'd0);
    send_tick(0);

    settle();
    write_reg(REG_BLED, LED_COUNT);
    write_reg(REG_SPEED, 32'(SPEED_SLOW));
    send_tick(1);

    // breathing on a LED number past the ring
    settle();
    write_reg(REG_BLED, 32'd7);
    send_tick(1);

    settle();
    write_reg(REG_MODE, 32'd3);
    send_tick(1);

    settle();
    write_reg(REG_NONE + 3'd1, 32'hFFFF_FFFF);
    send_tick(1);

    for (int pass = 0; pass < 3; pass++) begin
      send_idle = (pass == 0) ? 25 : (pass == 1) ? 79 : 0;
      recv_idle = (pass == 0) ? 79 : (pass == 1) ? 25 : 0;
      for (int phase = 0; phase < 2; phase++) begin
        case ($urandom_range(9))
          0, 1, 2, 3: m = MODE_METEOR;
          4, 5, 6, 7: m = MODE_BREATH;
          8:          m = 2'd0;
          default:    m = 2'd3;
        endcase
        b = ($urandom_range(7) == 0) ? 3'd7 : 3'($urandom_range(LED_COUNT));
        cr = COLOR_W'($urandom());
        cg = COLOR_W'($urandom());
        cb = COLOR_W'($urandom());
        settle();
        write_reg(REG_RED, noisy(32'(cr), COLOR_W));
        write_reg(REG_GREEN, noisy(32'(cg), COLOR_W));
        write_reg(REG_BLUE, noisy(32'(cb), COLOR_W));
        write_reg(REG_BLED, noisy(32'(b), 3));
        write_reg(REG_SPEED, noisy($urandom_range(3), 2));
        write_reg(REG_MODE, noisy(32'(m), 2));
        if ($urandom_range(3) == 0)
          write_reg(3'(REG_NONE + $urandom_range(1)), $urandom());
        for (int n = 0; n < 40; n++) begin
          send_tick($urandom_range(5) != 0);
        end
      end
    end

    settle();
    $display("%0d tick transfers over %0d effect settings, %0d LED writes checked",
             ticks_sent, settings, board.checked);
    $display("meteor, breathing, off and out-of-range settings under three idle patterns");
    if (board.mismatches == 0) begin
      $display("led_effect_sequencer_top_test OK");
    end else begin
      $display("led_effect_sequencer_top_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/les_pkg.sv
sv/les_div_unit.sv
sv/led_effect_sequencer_top.sv
sv/les_checker.sv
tb/led_effect_sequencer_top_test.sv
